// ===== rtl/core/bilinear_vector_map_sampler_top_assert.svh =====
// Assertion macros shared by the bilinear vector map sampler RTL.
// Needs only clock and reset names passed by the user.
`ifndef BILINEAR_VECTOR_MAP_SAMPLER_TOP_ASSERT_SVH
`define BILINEAR_VECTOR_MAP_SAMPLER_TOP_ASSERT_SVH
// implication checked every clock, off during reset
`define BVMS_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// next-cycle implication
`define BVMS_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

// ===== rtl/core/bvms_pkg.sv =====
// Types and constants for the bilinear vector map sampler.
// No dependencies.
package bvms_pkg;
   localparam int COMP_W     = 16;
   localparam int POS_W      = 14;
   localparam int IDX_W      = 12;
   localparam int DIM_W      = 7;
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int ADDR_W     = $clog2(MAX_WIDTH*MAX_HEIGHT);

   typedef enum logic {CMD_LOAD = 1'b0, CMD_SAMPLE = 1'b1} cmd_type;
   typedef enum logic {CSR_WIDTH = 1'b0, CSR_HEIGHT = 1'b1} csr_idx_type;

   typedef struct packed {
      logic               command;
      logic [IDX_W-1:0]   load_index;
      logic signed [COMP_W-1:0] vec_re;
      logic signed [COMP_W-1:0] vec_im;
      logic [POS_W-1:0]   x_pos;
      logic [POS_W-1:0]   y_pos;
   } req_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] out_re;
      logic signed [COMP_W-1:0] out_im;
      logic                     clamped;
   } rsp_type;
endpackage

// ===== rtl/core/bvms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bvms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/core/bvms_front.sv =====
// Front end: accepts requests, clamps coordinates, forms weights and addresses.
// Depends on bvms_pkg.
module bvms_front #(
   parameter int FRAC_BITS  = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  bvms_pkg::req_type    in_req,
   input  logic [bvms_pkg::DIM_W-1:0] width_cfg,
   input  logic [bvms_pkg::DIM_W-1:0] height_cfg,
   input  logic                 advance,
   output logic                 wr_en,
   output logic [bvms_pkg::ADDR_W-1:0] wr_addr,
   output logic [2*bvms_pkg::COMP_W-1:0] wr_data,
   output logic                 smp_valid,
   output logic [4*bvms_pkg::ADDR_W-1:0] smp_addr,
   output logic [4*(2*FRAC_BITS+2)-1:0] smp_wt,
   output logic                 smp_clamp
);
   import bvms_pkg::*;
   localparam int AW = ADDR_W;
   localparam int XW = $clog2(MAX_WIDTH) + 1;
   localparam int YW = $clog2(MAX_HEIGHT) + 1;
   localparam int IW = POS_W - FRAC_BITS;
   localparam int WW = 2*FRAC_BITS + 2;
   localparam int CW = (IW > XW ? IW : XW) + (IW > YW ? IW : YW) + 1;

   logic [XW-1:0] w_eff;
   logic [YW-1:0] h_eff;
   logic [IW-1:0] xi, yi;
   logic [FRAC_BITS:0] fx, fy, gx, gy;
   logic [CW-1:0] i0, i1, j0, j1, prod;
   logic clip_x, clip_y, fire;

   always_comb begin
      if (width_cfg == '0) w_eff = XW'(1);
      else if (32'(width_cfg) > MAX_WIDTH) w_eff = XW'(MAX_WIDTH);
      else w_eff = XW'(width_cfg);
      if (height_cfg == '0) h_eff = YW'(1);
      else if (32'(height_cfg) > MAX_HEIGHT) h_eff = YW'(MAX_HEIGHT);
      else h_eff = YW'(height_cfg);
      xi = in_req.x_pos[POS_W-1:FRAC_BITS];
      yi = in_req.y_pos[POS_W-1:FRAC_BITS];
      clip_x = CW'(xi) >= CW'(w_eff);
      clip_y = CW'(yi) >= CW'(h_eff);
      i0 = clip_x ? CW'(w_eff) - CW'(1) : CW'(xi);
      j0 = clip_y ? CW'(h_eff) - CW'(1) : CW'(yi);
      fx = clip_x ? '0 : {1'b0, in_req.x_pos[FRAC_BITS-1:0]};
      fy = clip_y ? '0 : {1'b0, in_req.y_pos[FRAC_BITS-1:0]};
      gx = (FRAC_BITS+1)'(1 << FRAC_BITS) - fx;
      gy = (FRAC_BITS+1)'(1 << FRAC_BITS) - fy;
      i1 = (i0 + CW'(1) < CW'(w_eff)) ? i0 + CW'(1) : i0;
      j1 = (j0 + CW'(1) < CW'(h_eff)) ? j0 + CW'(1) : j0;
      prod = CW'(w_eff) * CW'(h_eff);
      fire = in_valid && advance;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_en <= 1'b0;
         smp_valid <= 1'b0;
      end else if (advance) begin
         wr_en <= fire && in_req.command == CMD_LOAD && CW'(in_req.load_index) < prod;
         smp_valid <= fire && in_req.command == CMD_SAMPLE;
      end
      if (advance) begin
         wr_addr  <= in_req.load_index[AW-1:0];
         wr_data  <= {COMP_W'(in_req.vec_re), COMP_W'(in_req.vec_im)};
         smp_addr <= {AW'(j0 * CW'(w_eff) + i0), AW'(j0 * CW'(w_eff) + i1),
                      AW'(j1 * CW'(w_eff) + i0), AW'(j1 * CW'(w_eff) + i1)};
         smp_wt   <= {WW'(gx * gy), WW'(fx * gy), WW'(gx * fy), WW'(fx * fy)};
         smp_clamp <= clip_x | clip_y;
      end
   end
endmodule

// ===== rtl/core/bvms_back.sv =====
// Back end: four RAM banks, weighted sum, rounding and output skid queue.
// Depends on bvms_pkg and bvms_ram.
module bvms_back #(
   parameter int FRAC_BITS  = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [bvms_pkg::ADDR_W-1:0] wr_addr,
   input  logic [2*bvms_pkg::COMP_W-1:0] wr_data,
   input  logic                 smp_valid,
   input  logic [4*bvms_pkg::ADDR_W-1:0] smp_addr,
   input  logic [4*(2*FRAC_BITS+2)-1:0] smp_wt,
   input  logic                 smp_clamp,
   output logic                 advance,
   output logic                 out_valid,
   output bvms_pkg::rsp_type    out_rsp,
   input  logic                 out_stall
);
   import bvms_pkg::*;
   localparam int AW = ADDR_W;
   localparam int WW = 2*FRAC_BITS + 2;
   localparam int PW = COMP_W + WW + 1;
   localparam int SW = PW + 2;
   localparam int QD = 4;
   localparam int QA = 2;

   logic [2*COMP_W-1:0] rd [4];
   logic [4*WW-1:0] wt_ff;
   logic v1_ff, v2_ff, v3_ff, c1_ff, c2_ff, c3_ff;
   logic signed [PW-1:0] pre_ff [4], pim_ff [4];
   logic signed [SW-1:0] sre, sim, rre, rim;
   logic [COMP_W-1:0] rnd_re_ff, rnd_im_ff;
   rsp_type q_ff [QD];
   logic [QA-1:0] wp_ff, rp_ff;
   logic [QA:0] cnt_ff, cnt_in;
   logic push, pop;

   for (genvar k = 0; k < 4; k++) begin : g_bank
      bvms_ram #(.WIDTH(2*COMP_W), .DEPTH(MAX_WIDTH*MAX_HEIGHT)) u_ram (
         .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
         .rd_en(advance), .rd_addr(smp_addr[(3-k)*AW +: AW]), .rd_data(rd[k]));
   end

   // hold the whole pipe while a finished result waits on a full queue
   assign advance = !(v3_ff && cnt_ff == (QA+1)'(QD));
   assign pop  = (cnt_ff != '0) && !out_stall;
   assign push = v3_ff && advance;

   always_comb begin
      sre = '0;
      sim = '0;
      for (int k = 0; k < 4; k++) begin
         sre = sre + SW'(pre_ff[k]);
         sim = sim + SW'(pim_ff[k]);
      end
      rre = (sre + SW'(1 << (2*FRAC_BITS-1))) >>> (2*FRAC_BITS);
      rim = (sim + SW'(1 << (2*FRAC_BITS-1))) >>> (2*FRAC_BITS);
      cnt_in = cnt_ff + (QA+1)'(push) - (QA+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (advance) begin
            v1_ff <= smp_valid; v2_ff <= v1_ff; v3_ff <= v2_ff;
         end
         if (push) wp_ff <= wp_ff + QA'(1);
         if (pop) rp_ff <= rp_ff + QA'(1);
         cnt_ff <= cnt_in;
      end
      if (advance) begin
         wt_ff <= smp_wt;
         c1_ff <= smp_clamp; c2_ff <= c1_ff; c3_ff <= c2_ff;
         for (int k = 0; k < 4; k++) begin
            pre_ff[k] <= PW'($signed(rd[k][2*COMP_W-1:COMP_W]))
                       * PW'($signed({1'b0, wt_ff[(3-k)*WW +: WW]}));
            pim_ff[k] <= PW'($signed(rd[k][COMP_W-1:0]))
                       * PW'($signed({1'b0, wt_ff[(3-k)*WW +: WW]}));
         end
         // register the rounded sum so it lines up with v3_ff
         rnd_re_ff <= COMP_W'(rre);
         rnd_im_ff <= COMP_W'(rim);
      end
      if (push) q_ff[wp_ff] <= '{out_re: rnd_re_ff, out_im: rnd_im_ff,
                                 clamped: c3_ff};
   end

   assign out_valid = cnt_ff != '0;
   assign out_rsp = q_ff[rp_ff];

   `include "bilinear_vector_map_sampler_top_assert.svh"
   `BVMS_ASSERT_IMP(a_no_overflow, clock, reset, push, cnt_ff < (QA+1)'(QD))
   `BVMS_ASSERT_NXT(a_pop_count, clock, reset, pop && !push, cnt_ff == $past(cnt_ff) - 1'b1)
   `BVMS_ASSERT_IMP(a_valid_cnt, clock, reset, out_valid, cnt_ff != '0)
endmodule

// ===== rtl/core/bilinear_vector_map_sampler_top.sv =====
// Bilinear vector map sampler: one request per cycle sustained, but requests
// stall whenever the four-entry result queue is full and a finished result
// waits to enter it. A load writes one vector to four mirrored RAM banks; a
// sample reads its four neighbors from those banks together, and its result
// passes the front registers, RAM read, products, rounded sum and the queue.
// Depends on bvms_pkg, bvms_front, bvms_back.
module bilinear_vector_map_sampler_top #(
   parameter int FRAC_BITS  = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bvms_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bvms_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [bvms_pkg::DIM_W-1:0] csr_data
);
   import bvms_pkg::*;
   localparam int AW = ADDR_W;
   localparam int WW = 2*FRAC_BITS + 2;

   logic [DIM_W-1:0] width_ff, height_ff;
   logic advance, wr_en, smp_valid, smp_clamp;
   logic [AW-1:0] wr_addr;
   logic [2*COMP_W-1:0] wr_data;
   logic [4*AW-1:0] smp_addr;
   logic [4*WW-1:0] smp_wt;

   assign csr_ready = 1'b1;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(64);
         height_ff <= DIM_W'(64);
      end else if (csr_valid) begin
         if (csr_index == CSR_WIDTH) width_ff <= csr_data;
         else height_ff <= csr_data;
      end
   end

   bvms_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock, .reset, .in_valid(req_valid), .in_req(req_data),
      .width_cfg(width_ff), .height_cfg(height_ff), .advance,
      .wr_en, .wr_addr, .wr_data, .smp_valid, .smp_addr, .smp_wt, .smp_clamp);

   bvms_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .wr_en, .wr_addr, .wr_data, .smp_valid, .smp_addr,
      .smp_wt, .smp_clamp, .advance, .out_valid(rsp_valid), .out_rsp(rsp_data),
      .out_stall(rsp_stall));
endmodule

// ===== bench/bilinear_vector_map_sampler_top_test.sv =====
// Self-checking bench for the bilinear vector map sampler: loads vectors, samples the map
// under several map sizes; each result is matched to a bench interpolation or fixed value.
// Depends on bvms_pkg and bilinear_vector_map_sampler_top.
module bilinear_vector_map_sampler_top_test;
   import bvms_pkg::*;

   localparam int MAP_MAX   = 64;
   localparam int CYCLE_CAP = 2000000;
   localparam int LONG_HOLD = 400;
   localparam int PASS_ITEMS = 175;

   typedef struct {
      req_type r;
      bit      fixed;
      rsp_type e;
   } stim_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_index;
   logic [DIM_W-1:0] csr_data;

   stim_type pending_q[$];
   rsp_type  sample_q[$];
   stim_type cur_req;
   int       gap_cnt;
   int       errors;
   int       samples_seen;
   int       loads_sent;
   int       items_queued;
   int       cycle_cnt;
   bit       hold_req;
   int       hold_cnt;

   // model state: map contents and the sizes seen by the block
   logic signed [COMP_W-1:0] map_re[MAP_MAX*MAP_MAX];
   logic signed [COMP_W-1:0] map_im[MAP_MAX*MAP_MAX];
   logic [DIM_W-1:0] cur_w;
   logic [DIM_W-1:0] cur_h;
   // entries loaded so far, tracked as requests are generated
   bit gen_written[MAP_MAX*MAP_MAX];

   bilinear_vector_map_sampler_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int dim_used(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAP_MAX) return MAP_MAX;
      return int'(v);
   endfunction

   function automatic logic signed [COMP_W-1:0] blend_comp(longint p00, longint p01,
         longint p10, longint p11, longint fx, longint fy);
      longint total;
      total = (256 - fx) * (256 - fy) * p00 + fx * (256 - fy) * p01
            + (256 - fx) * fy * p10 + fx * fy * p11;
      // floor after adding half gives ties toward plus infinity
      total = (total + 64'sd32768) >>> 16;
      return total[COMP_W-1:0];
   endfunction

   // apply one request to the model; return 1 with the sample result for samples
   function automatic bit interpolate(req_type r, output rsp_type o);
      int w, h, i0, j0, i1, j1, fx, fy;
      bit clip;
      w = dim_used(cur_w);
      h = dim_used(cur_h);
      o = '0;
      if (r.command == CMD_LOAD) begin
         if (int'(r.load_index) < w * h) begin
            map_re[r.load_index] = r.vec_re;
            map_im[r.load_index] = r.vec_im;
         end
         return 1'b0;
      end
      i0 = r.x_pos >> 8;
      j0 = r.y_pos >> 8;
      fx = r.x_pos & 8'hFF;
      fy = r.y_pos & 8'hFF;
      clip = 1'b0;
      if (i0 >= w) begin
         i0 = w - 1; fx = 0; clip = 1'b1;
      end
      if (j0 >= h) begin
         j0 = h - 1; fy = 0; clip = 1'b1;
      end
      i1 = (i0 + 1 < w) ? i0 + 1 : w - 1;
      j1 = (j0 + 1 < h) ? j0 + 1 : h - 1;
      o.out_re = blend_comp(map_re[i0+j0*w], map_re[i1+j0*w], map_re[i0+j1*w],
                            map_re[i1+j1*w], fx, fy);
      o.out_im = blend_comp(map_im[i0+j0*w], map_im[i1+j0*w], map_im[i0+j1*w],
                            map_im[i1+j1*w], fx, fy);
      o.clamped = clip;
      return 1'b1;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 85) return 0;
      if (roll < 97) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // request side: hold payload while stalled, advance on accept
   always @(posedge clock) begin
      rsp_type o;
      if (reset) begin
         req_valid <= 1'b0;
         gap_cnt = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (interpolate(cur_req.r, o))
               sample_q.push_back(cur_req.fixed ? cur_req.e : o);
         end
         if (!req_valid || !req_stall) begin
            if (gap_cnt > 0) begin
               gap_cnt--;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               cur_req = pending_q.pop_front();
               req_valid <= 1'b1;
               req_data <= cur_req.r;
               gap_cnt = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side: check against the oldest expectation, stall at random
   always @(posedge clock) begin
      rsp_type e;
      cycle_cnt++;
      if (cycle_cnt > CYCLE_CAP) begin
         $display("Simulation FAILED");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sample_q.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, rsp_data);
            errors++;
         end else begin
            e = sample_q.pop_front();
            samples_seen++;
            if (rsp_data.out_re !== e.out_re || rsp_data.out_im !== e.out_im ||
                rsp_data.clamped !== e.clamped) begin
               $display("%0t: mismatch expected re=%0d im=%0d cl=%0d actual re=%0d im=%0d cl=%0d",
                        $realtime, e.out_re, e.out_im, e.clamped,
                        rsp_data.out_re, rsp_data.out_im, rsp_data.clamped);
               errors++;
            end
         end
      end
      if (hold_req) begin
         hold_req = 1'b0;
         hold_cnt = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 20) ||
                      ($urandom_range(0, 199) == 0 && !rsp_stall);
      end
   end

   function automatic stim_type mk(bit cmd, int idx, int re, int im, int x, int y,
                                   bit fixed = 0, int ere = 0, int eim = 0, bit ecl = 0);
      stim_type s;
      s.r = '0;
      s.r.command    = cmd ? CMD_SAMPLE : CMD_LOAD;
      s.r.load_index = IDX_W'(idx);
      s.r.vec_re     = COMP_W'(re);
      s.r.vec_im     = COMP_W'(im);
      s.r.x_pos      = POS_W'(x);
      s.r.y_pos      = POS_W'(y);
      s.fixed        = fixed;
      s.e.out_re     = COMP_W'(ere);
      s.e.out_im     = COMP_W'(eim);
      s.e.clamped    = ecl;
      return s;
   endfunction

   function automatic logic [COMP_W-1:0] rnd_comp();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return COMP_W'($urandom);
      endcase
   endfunction

   function automatic stim_type rnd_load(int idx);
      stim_type s;
      s = mk(0, idx, 0, 0, $urandom_range(0, 16383), $urandom_range(0, 16383));
      s.r.vec_re = rnd_comp();
      s.r.vec_im = rnd_comp();
      return s;
   endfunction

   // noise load anywhere, possibly past the map
   task automatic add_load(int w, int h);
      stim_type s;
      int idx;
      idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                        : $urandom_range(0, w * h - 1);
      s = rnd_load(idx);
      if (idx < w * h) gen_written[idx] = 1'b1;
      pending_q.push_back(s);
      loads_sent++;
      items_queued++;
   endtask

   // sample; first load any neighbor that was never written
   task automatic add_sample(int w, int h);
      stim_type s;
      int x, y, i0, j0, i1, j1;
      int nb[4];
      x = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, w*256-1);
      y = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, h*256-1);
      i0 = x >> 8;
      j0 = y >> 8;
      if (i0 >= w) i0 = w - 1;
      if (j0 >= h) j0 = h - 1;
      i1 = (i0 + 1 < w) ? i0 + 1 : w - 1;
      j1 = (j0 + 1 < h) ? j0 + 1 : h - 1;
      nb = '{i0 + j0*w, i1 + j0*w, i0 + j1*w, i1 + j1*w};
      foreach (nb[k]) begin
         if (!gen_written[nb[k]]) begin
            pending_q.push_back(rnd_load(nb[k]));
            gen_written[nb[k]] = 1'b1;
            loads_sent++;
            items_queued++;
         end
      end
      s = mk(1, $urandom_range(0, 4095), 0, 0, x, y);
      s.r.vec_re = COMP_W'($urandom);
      s.r.vec_im = COMP_W'($urandom);
      pending_q.push_back(s);
      items_queued++;
   endtask

   task automatic drain();
      wait (pending_q.size() == 0 && !req_valid && sample_q.size() == 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [DIM_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_WIDTH) cur_w = val;
      else cur_h = val;
   endtask

   initial begin
      stim_type directed[$];
      int cfg_w[9];
      int cfg_h[9];
      int w, h;
      int pass_start;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_WIDTH;
      csr_data = '0;
      errors = 0;
      samples_seen = 0;
      loads_sent = 0;
      items_queued = 0;
      cycle_cnt = 0;
      hold_req = 1'b0;
      hold_cnt = 0;
      cur_w = DIM_W'(64);
      cur_h = DIM_W'(64);
      foreach (map_re[k]) begin
         map_re[k] = '0;
         map_im[k] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part under the reset map size of 64 by 64
      directed = '{
         mk(0, 0, 32767, -32768, 0, 0),
         mk(0, 1, -32768, 32767, 16383, 16383),
         mk(0, 64, 0, 0, 0, 0),
         mk(0, 65, 1, -1, 0, 0),
         mk(0, 4095, -1, 1, 0, 0),
         mk(0, 4032, 100, -100, 0, 0),
         mk(0, 4033, 200, -200, 0, 0),
         mk(1, 0, 0, 0, 0, 0, 1, 32767, -32768, 0),
         mk(1, 4095, -1, -1, 8'h80, 0, 1, 0, 0, 0),
         mk(1, 0, 0, 0, 8'h80, 8'h80),
         mk(1, 0, 0, 0, 8'hFF, 8'hFF),
         mk(1, 0, 0, 0, 16383, 16383, 1, -1, 1, 0),
         mk(1, 0, 0, 0, 63*256 + 8'h40, 16383, 1, -1, 1, 0),
         mk(1, 0, 0, 0, 8'h40, 16383),
         mk(1, 0, 0, 0, 16383, 8'h40)
      };
      foreach (directed[k]) begin
         if (directed[k].r.command == CMD_LOAD) begin
            gen_written[directed[k].r.load_index] = 1'b1;
            loads_sent++;
         end
         pending_q.push_back(directed[k]);
         items_queued++;
      end
      drain();

      cfg_w = '{64, 1, 0, 127, 1, 64, 5, 0, 0};
      cfg_h = '{64, 1, 0, 127, 64, 1, 3, 0, 0};
      cfg_w[7] = $urandom_range(1, 64);
      cfg_h[7] = $urandom_range(1, 64);
      cfg_w[8] = $urandom_range(0, 127);
      cfg_h[8] = $urandom_range(0, 127);
      for (int p = 0; p < 9; p++) begin
         write_reg(CSR_WIDTH, DIM_W'(cfg_w[p]));
         write_reg(CSR_HEIGHT, DIM_W'(cfg_h[p]));
         w = dim_used(cur_w);
         h = dim_used(cur_h);
         // hold off results for a long stretch while requests keep coming
         if (p == 3) hold_req = 1'b1;
         pass_start = items_queued;
         for (int n = 0; items_queued - pass_start < PASS_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 70) add_sample(w, h);
            else add_load(w, h);
            // pause the sender until every result is back
            if (n == 20) begin
               wait (pending_q.size() == 0 && !req_valid && sample_q.size() == 0);
            end
            if (pending_q.size() > 8) wait (pending_q.size() <= 8);
         end
         drain();
      end

      $display("Covered %0d samples and %0d loads over nine map sizes, incl. 1x1 and out-of-range",
               samples_seen, loads_sent);
      $display("registers, clamped coordinates, long result hold-off and sender pauses.");
      if (errors == 0 && sample_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
